// File: rtl/mpms_pkg.sv
// Package: widths, mask mode codes and rounding constants for the masked pixel merge.
`default_nettype none
package mpms_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int PIX_W         = 18;
   localparam int SAMPLE_W      = 17;
   localparam int SUM_W         = SAMPLE_W + 1;
   localparam int WEIGHT_W      = SUM_W + 2;               // weight in 1/8 units
   localparam int DIFF_W        = PIX_W + 1;
   localparam int PROD_W        = WEIGHT_W + 1 + DIFF_W;
   localparam int SHIFT         = FRACTION_BITS + 3;
   localparam int QMAG_W        = PROD_W + 1 - SHIFT;
   localparam int Q_W           = QMAG_W + 1;
   localparam int R_W           = Q_W + 1;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (SHIFT - 1);
   localparam logic signed [R_W-1:0] PIX_MAX = R_W'((2 ** (PIX_W - 1)) - 1);
   localparam logic signed [R_W-1:0] PIX_MIN = -R_W'(2 ** (PIX_W - 1));

   typedef enum logic [1:0] {
      MODE_FULL  = 2'd0,
      MODE_PAIR  = 2'd1,
      MODE_BLOCK = 2'd2,
      MODE_SITED = 2'd3
   } mask_mode_type;

endpackage
`default_nettype wire

// File: rtl/mpms_if.sv
// Interfaces: request and response channels of the masked pixel merge.
`default_nettype none
interface mpms_req_if import mpms_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [PIX_W-1:0]    dst_pixel;
   logic signed [PIX_W-1:0]    src_pixel;
   logic        [SAMPLE_W-1:0] mask_top_even;
   logic        [SAMPLE_W-1:0] mask_top_odd;
   logic        [SAMPLE_W-1:0] mask_bottom_even;
   logic        [SAMPLE_W-1:0] mask_bottom_odd;
   logic                       row_start;

   modport source (
      output valid, dst_pixel, src_pixel, mask_top_even, mask_top_odd,
             mask_bottom_even, mask_bottom_odd, row_start,
      input  ready
   );
   modport sink (
      input  valid, dst_pixel, src_pixel, mask_top_even, mask_top_odd,
             mask_bottom_even, mask_bottom_odd, row_start,
      output ready
   );
endinterface

interface mpms_rsp_if import mpms_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] merged_pixel;

   modport source (output valid, merged_pixel, input ready);
   modport sink   (input valid, merged_pixel, output ready);
endinterface
`default_nettype wire

// File: rtl/masked_pixel_merge_subsampled_top.sv
// A result passes through the weight/difference, product and output registers after its request transaction.
// Throughput: one transaction per cycle unless the output stalls; weight adders, then the weight x
// difference multiplier, then rounding/clamp each own one pipeline stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active high) empties the pipeline, sets mask_mode to
// full and clears the previous odd column sum.
`default_nettype none
module masked_pixel_merge_subsampled_top import mpms_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   mpms_req_if.sink        req,
   mpms_rsp_if.source      rsp,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);

   mask_mode_type mode_ff;
   logic [SUM_W-1:0] prev_odd_ff;

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [WEIGHT_W-1:0]     w8_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PIX_W-1:0]  dst1_ff, dst2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PIX_W-1:0]  merged_ff;

   logic advance, accept;
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && advance;
   assign req.ready = advance;

   // weight in units of 1/8 sample
   logic [SUM_W-1:0]    even_sum, odd_sum, pair_sum, left_sum;
   logic [SUM_W:0]      block_sum;
   logic [WEIGHT_W-1:0] w8_in;
   logic signed [DIFF_W-1:0] diff_in;

   assign even_sum  = SUM_W'(req.mask_top_even) + SUM_W'(req.mask_bottom_even);
   assign odd_sum   = SUM_W'(req.mask_top_odd) + SUM_W'(req.mask_bottom_odd);
   assign pair_sum  = SUM_W'(req.mask_top_even) + SUM_W'(req.mask_top_odd);
   assign block_sum = (SUM_W + 1)'(even_sum) + (SUM_W + 1)'(odd_sum);
   assign left_sum  = req.row_start ? even_sum : prev_odd_ff;
   assign diff_in   = {req.src_pixel[PIX_W-1], req.src_pixel}
                    - {req.dst_pixel[PIX_W-1], req.dst_pixel};

   always_comb begin
      unique case (mode_ff)
         MODE_FULL:  w8_in = WEIGHT_W'({req.mask_top_even, 3'b000});
         MODE_PAIR:  w8_in = WEIGHT_W'({pair_sum, 2'b00});
         MODE_BLOCK: w8_in = WEIGHT_W'({block_sum, 1'b0});
         MODE_SITED: w8_in = WEIGHT_W'(left_sum) + WEIGHT_W'({even_sum, 1'b0})
                           + WEIGHT_W'(odd_sum);
         default:    w8_in = '0;
      endcase
   end

   // rounding to nearest, ties away from zero, then clamp
   logic                     prod_neg;
   logic [PROD_W-1:0]        prod_mag;
   logic [PROD_W:0]          prod_rnd;
   logic [QMAG_W-1:0]        q_mag;
   logic signed [Q_W-1:0]    q_val;
   logic signed [R_W-1:0]    r_val;
   logic signed [PIX_W-1:0]  merged_in;

   assign prod_neg = prod_ff[PROD_W-1];
   assign prod_mag = prod_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign prod_rnd = {1'b0, prod_mag} + ROUND_HALF;
   assign q_mag    = prod_rnd[PROD_W:SHIFT];
   assign q_val    = prod_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   assign r_val    = R_W'(dst2_ff) + R_W'(q_val);

   always_comb begin
      priority if (r_val > PIX_MAX) begin
         merged_in = PIX_MAX[PIX_W-1:0];
      end else if (r_val < PIX_MIN) begin
         merged_in = PIX_MIN[PIX_W-1:0];
      end else begin
         merged_in = r_val[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_FULL;
         prev_odd_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= mask_mode_type'(csr_wr_data);
         end
         if (accept) begin
            prev_odd_ff <= odd_sum;
         end
         if (advance) begin
            s1_valid_ff  <= req.valid;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w8_ff     <= w8_in;
         diff_ff   <= diff_in;
         dst1_ff   <= req.dst_pixel;
         prod_ff   <= $signed({1'b0, w8_ff}) * diff_ff;
         dst2_ff   <= dst1_ff;
         merged_ff <= merged_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.merged_pixel = merged_ff;

endmodule
`default_nettype wire

// File: tb/sv/mpms_checker.sv
// Checker: predicts each merged pixel from the request and mask mode traffic and compares responses.
module mpms_checker import mpms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mpms_req_if        req,
   mpms_rsp_if        rsp,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output int         mismatch_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   mask_mode_type           cur_mode;
   logic [SUM_W-1:0]        last_odd_sum;
   logic signed [PIX_W-1:0] expected_merged[$];

   // Weight kept in 1/8 LSB units, product rounded once, ties away from zero.
   function automatic logic signed [PIX_W-1:0] blend_pixel(
      input mask_mode_type           mode,
      input logic [SUM_W-1:0]        prev_odd,
      input logic signed [PIX_W-1:0] dst,
      input logic signed [PIX_W-1:0] src,
      input logic [SAMPLE_W-1:0]     te,
      input logic [SAMPLE_W-1:0]     to,
      input logic [SAMPLE_W-1:0]     be,
      input logic [SAMPLE_W-1:0]     bo,
      input logic                    row_start
   );
      longint even_sum, odd_sum, left_sum, w8, prod, mag, q, r;
      even_sum = longint'(te) + longint'(be);
      odd_sum  = longint'(to) + longint'(bo);
      case (mode)
         MODE_FULL: begin
            w8 = longint'(te) * 8;
         end
         MODE_PAIR: begin
            w8 = (longint'(te) + longint'(to)) * 4;
         end
         MODE_BLOCK: begin
            w8 = (even_sum + odd_sum) * 2;
         end
         default: begin
            left_sum = row_start ? even_sum : longint'(prev_odd);
            w8 = left_sum + 2 * even_sum + odd_sum;
         end
      endcase
      prod = w8 * (longint'(src) - longint'(dst));
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
      if (prod < 0) q = -q;
      r = longint'(dst) + q;
      if (r > longint'(PIX_MAX)) r = longint'(PIX_MAX);
      if (r < longint'(PIX_MIN)) r = longint'(PIX_MIN);
      return PIX_W'(r);
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin : monitor
      logic signed [PIX_W-1:0] want;
      if (reset) begin
         cur_mode     <= MODE_FULL;
         last_odd_sum <= '0;
         expected_merged.delete();
         outstanding  <= 0;
      end else begin
         if (csr_wr_en) cur_mode <= mask_mode_type'(csr_wr_data);
         // check the response first so a same-edge request cannot satisfy it
         if (rsp.valid && rsp.ready) begin
            if (expected_merged.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected merged pixel %0d", rsp.merged_pixel);
               mismatch_count++;
            end else begin
               want = expected_merged.pop_front();
               if (rsp.merged_pixel !== want) begin
                  if (mismatch_count < 10)
                     $display("merged pixel mismatch: expected %0d, got %0d",
                              want, rsp.merged_pixel);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_merged.push_back(blend_pixel(cur_mode, last_odd_sum,
               req.dst_pixel, req.src_pixel, req.mask_top_even, req.mask_top_odd,
               req.mask_bottom_even, req.mask_bottom_odd, req.row_start));
            // odd column sum carried on every transaction, whatever the mode
            last_odd_sum <= SUM_W'(req.mask_top_odd) + SUM_W'(req.mask_bottom_odd);
         end
         outstanding <= expected_merged.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: clock, reset, mask mode writes, pixel stimulus, response back-pressure and verdict.
module tb_top;
   import mpms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MASK_ONE  = 1 << FRACTION_BITS;
   localparam int MASK_HALF = MASK_ONE / 2;
   localparam logic signed [PIX_W-1:0] PIX_HIGH = PIX_W'(PIX_MAX);
   localparam logic signed [PIX_W-1:0] PIX_LOW  = PIX_W'(PIX_MIN);

   typedef struct {
      logic signed [PIX_W-1:0] dst;
      logic signed [PIX_W-1:0] src;
      logic [SAMPLE_W-1:0]     te;
      logic [SAMPLE_W-1:0]     to;
      logic [SAMPLE_W-1:0]     be;
      logic [SAMPLE_W-1:0]     bo;
      logic                    row_start;
   } merge_req_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;
   bit         no_idle;
   int         mismatch_count;
   int         outstanding;

   mpms_req_if req_ch ();
   mpms_rsp_if rsp_ch ();

   masked_pixel_merge_subsampled_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mpms_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("masked_pixel_merge_subsampled_top: mismatch");
      $finish;
   end

   function automatic merge_req_type make_req(
      input logic signed [PIX_W-1:0] dst,
      input logic signed [PIX_W-1:0] src,
      input int te, input int to, input int be, input int bo,
      input logic row_start
   );
      merge_req_type p;
      p.dst = dst;
      p.src = src;
      p.te  = SAMPLE_W'(te);
      p.to  = SAMPLE_W'(to);
      p.be  = SAMPLE_W'(be);
      p.bo  = SAMPLE_W'(bo);
      p.row_start = row_start;
      return p;
   endfunction

   function automatic logic signed [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return PIX_LOW;
         1: return PIX_HIGH;
         2: return PIX_W'(int'($urandom_range(0, 200)) - 100);
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return MASK_ONE;
         2: return MASK_HALF + int'($urandom_range(0, 4)) - 2;
         default: return int'($urandom_range(0, MASK_ONE));
      endcase
   endfunction

   // caller sits at a rising edge; returns at the edge of the transaction
   task automatic send_merge(input merge_req_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.dst_pixel        <= p.dst;
      req_ch.src_pixel        <= p.src;
      req_ch.mask_top_even    <= p.te;
      req_ch.mask_top_odd     <= p.to;
      req_ch.mask_bottom_even <= p.be;
      req_ch.mask_bottom_odd  <= p.bo;
      req_ch.row_start        <= p.row_start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_mask_mode(input mask_mode_type mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side back-pressure
   initial begin : rsp_stall
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      mask_mode_type phase_mode;
      merge_req_type p;
      int            row_left;
      reset       = 1'b1;
      no_idle     = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_ch.valid            = 1'b0;
      req_ch.dst_pixel        = '0;
      req_ch.src_pixel        = '0;
      req_ch.mask_top_even    = '0;
      req_ch.mask_top_odd     = '0;
      req_ch.mask_bottom_even = '0;
      req_ch.mask_bottom_odd  = '0;
      req_ch.row_start        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: full-scale steps both ways, zero weight, rounding ties of both signs,
      // sited left sum from the previous odd column and at row start
      for (int m = 0; m < 4; m++) begin
         write_mask_mode(mask_mode_type'(m));
         send_merge(make_req(PIX_LOW, PIX_HIGH, MASK_ONE, MASK_ONE, MASK_ONE,
                             MASK_ONE, 1'b1));
         send_merge(make_req(PIX_HIGH, PIX_LOW, MASK_ONE, MASK_ONE, MASK_ONE,
                             MASK_ONE, 1'b0));
         send_merge(make_req(PIX_W'(12345), PIX_W'(-7), 0, 0, 0, 0, 1'b0));
         send_merge(make_req(PIX_W'(0), PIX_W'(1), MASK_HALF, MASK_HALF, MASK_HALF,
                             MASK_HALF, 1'b1));
         send_merge(make_req(PIX_W'(5), PIX_W'(4), MASK_HALF, MASK_HALF, MASK_HALF,
                             MASK_HALF, 1'b0));
         send_merge(make_req(PIX_W'(-1000), PIX_W'(99999), MASK_ONE, 0, 0, MASK_ONE,
                             1'b0));
         drain_pipeline();
      end

      // random rows of pixels, with some row_start noise
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: phase_mode = MODE_SITED;
            1: phase_mode = MODE_FULL;
            2: phase_mode = MODE_PAIR;
            3: phase_mode = MODE_BLOCK;
            default: phase_mode = mask_mode_type'($urandom_range(0, 3));
         endcase
         no_idle = (ph == 2 || ph == 5);
         write_mask_mode(phase_mode);
         row_left = 0;
         repeat (190) begin
            p = make_req(rand_pixel(), rand_pixel(), rand_sample(), rand_sample(),
                         rand_sample(), rand_sample(), 1'b0);
            if (row_left == 0) begin
               row_left = $urandom_range(1, 16);
               p.row_start = 1'b1;
            end
            row_left--;
            if ($urandom_range(0, 9) == 0) p.row_start = 1'($urandom_range(0, 1));
            send_merge(p);
         end
         drain_pipeline();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("masked_pixel_merge_subsampled_top: match");
      end else begin
         $display("masked_pixel_merge_subsampled_top: mismatch");
      end
      $finish;
   end

endmodule
